FILE: src/rsb_pkg.sv
// rsb_pkg: command and status codes, entry type and helpers shared by the
// retransmit scoreboard cell row and its top level. No dependencies.
`default_nettype none

package rsb_pkg;

  localparam logic [2:0] CMD_SEND = 3'd0;
  localparam logic [2:0] CMD_CUM  = 3'd1;
  localparam logic [2:0] CMD_GAP  = 3'd2;
  localparam logic [2:0] CMD_MISS = 3'd3;
  localparam logic [2:0] CMD_FAST = 3'd4;
  localparam logic [2:0] CMD_MARK = 3'd5;
  localparam logic [2:0] CMD_RETX = 3'd6;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  localparam int unsigned RESULT_LIMIT = 64;
  localparam logic [21:0] BYTES_MAX = 22'h3FFFFF;

  typedef struct packed {
    logic [15:0] len;
    logic        acked;
    logic        retx;
    logic [1:0]  miss;
  } entry_t;

  // serial number compare: a after b
  function automatic logic tsn_gt(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

  function automatic logic [21:0] sat_add(input logic [21:0] s, input logic [15:0] v);
    logic [22:0] r;
    r = {1'b0, s} + {7'd0, v};
    return (r > {1'b0, BYTES_MAX}) ? BYTES_MAX : r[21:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/rsb_cell.sv
// rsb_cell: one scoreboard entry of the rotating cell row.
// Depends on rsb_pkg for the entry type.
`default_nettype none

module rsb_cell #(
  parameter int TRANSMIT_COUNT_WIDTH = 8
) (
  input  wire                                  clk,
  input  wire                                  shift_en,
  input  wire                                  wr_en,
  input  wire rsb_pkg::entry_t                 shift_ent,
  input  wire logic [TRANSMIT_COUNT_WIDTH-1:0] shift_tx,
  input  wire rsb_pkg::entry_t                 wr_ent,
  output rsb_pkg::entry_t                      ent,
  output logic [TRANSMIT_COUNT_WIDTH-1:0]      tx
);

  rsb_pkg::entry_t                 ent_r;
  logic [TRANSMIT_COUNT_WIDTH-1:0] tx_r;

  // send writes a fresh entry, sent once
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_r <= wr_ent;
      tx_r  <= TRANSMIT_COUNT_WIDTH'(1);
    end else if (shift_en) begin
      ent_r <= shift_ent;
      tx_r  <= shift_tx;
    end
  end

  assign ent = ent_r;
  assign tx  = tx_r;

endmodule

`default_nettype wire

FILE: src/sctp_retransmit_scoreboard.sv
// Retransmit scoreboard: a ring of QUEUE_DEPTH entry cells whose head sits
// at cell 0. Send and the unused command are answered straight from idle.
// A cumulative ack rotates out one retired entry per cycle, then goes to
// S_FIN. Every other command passes S_PREP1 and S_PREP2, then rotates the
// whole row once past the head cell, one entry per cycle, and ends in S_FIN;
// gathers give at most one emitted item per cycle during the rotation and the
// last item at the end. Results are strobed for one cycle and cannot be
// held off. Depends on rsb_pkg and rsb_cell.
`default_nettype none

module sctp_retransmit_scoreboard #(
  parameter int QUEUE_DEPTH          = 64,
  parameter int TRANSMIT_COUNT_WIDTH = 8
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  wire logic [2:0]   in_cmd,
  input  wire logic [31:0]  in_tsn_value,
  input  wire logic [15:0]  in_gap_start,
  input  wire logic [15:0]  in_gap_end,
  input  wire logic         in_first_block,
  input  wire logic [15:0]  in_chunk_length,
  input  wire logic         in_in_recovery,
  input  wire logic [15:0]  in_byte_budget,
  output logic              out_strobe,
  output logic [21:0]       out_acked_bytes,
  output logic [31:0]       out_highest_acked,
  output logic [31:0]       out_tsn,
  output logic [15:0]       out_length,
  output logic              out_enter_recovery,
  output logic [1:0]        out_status,
  output logic              out_last,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_data
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = TRANSMIT_COUNT_WIDTH;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP1 = 3'd1;
  localparam logic [2:0] S_PREP2 = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_CUM   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]    state_r;
  logic [1:0]    thr_r;
  logic [CW-1:0] cnt_r;
  logic [31:0]   cum_r, next_r;
  logic [CW-1:0] sp_r;
  logic          gfail_r, fp_r;
  logic [31:0]   ghigh_r;

  logic [2:0]    cmd_r;
  logic [31:0]   tval_r;
  logic [15:0]   gs_r, ge_r;
  logic          inrec_r;
  logic [31:0]   base_r, jstart_r;
  logic          ok_r, fpg_r;
  logic [CW-1:0] jfirst_r, jlast_r;
  logic [IW-1:0] step_r;
  logic [21:0]   sum_r;
  logic [15:0]   rem_r;
  logic          stop_r, reached_r;
  logic [6:0]    nemit_r;
  logic          hold_v_r;
  logic [31:0]   hold_tsn_r;
  logic [15:0]   hold_len_r;

  logic          out_strobe_r, out_enter_r, out_last_r;
  logic [21:0]   out_bytes_r;
  logic [31:0]   out_high_r, out_tsn_r;
  logic [15:0]   out_len_r;
  logic [1:0]    out_status_r;

  rsb_pkg::entry_t       ent_q [QUEUE_DEPTH];
  logic [TW-1:0]         tx_q  [QUEUE_DEPTH];
  rsb_pkg::entry_t       proc_ent, wr_ent;
  logic [TW-1:0]         proc_tx;
  logic                  shift_en, send_we;

  // head cell processing
  logic [1:0]    th;
  logic [CW-1:0] step_zx;
  logic          live, emit, hit, stop_set, reach_set, retire;
  logic [31:0]   tsn_i, t0;

  assign th      = (thr_r == 2'd0) ? 2'd1 : thr_r;
  assign step_zx = CW'(step_r);
  assign live    = step_zx < cnt_r;
  assign tsn_i   = base_r + 32'(step_r);
  assign t0      = next_r - 32'(cnt_r);
  assign retire  = (cnt_r != '0) && !rsb_pkg::tsn_gt(t0, tval_r);

  always_comb begin
    proc_ent  = ent_q[0];
    proc_tx   = tx_q[0];
    emit      = 1'b0;
    hit       = 1'b0;
    stop_set  = 1'b0;
    reach_set = 1'b0;
    if (state_r == S_WALK) begin
      case (cmd_r)
        rsb_pkg::CMD_GAP: begin
          if (ok_r && live && step_zx >= jfirst_r && step_zx <= jlast_r &&
              !ent_q[0].acked) begin
            proc_ent.acked = 1'b1;
            hit            = 1'b1;
          end
        end
        rsb_pkg::CMD_MISS: begin
          if (live && !stop_r) begin
            // entries strictly below the reported tsn count up
            if (tsn_i != tval_r && !rsb_pkg::tsn_gt(tsn_i, tval_r)) begin
              if (!ent_q[0].acked && ent_q[0].miss < th) begin
                proc_ent.miss = ent_q[0].miss + 2'd1;
                reach_set     = (ent_q[0].miss + 2'd1) == th;
              end
            end else begin
              stop_set = 1'b1;
            end
          end
        end
        rsb_pkg::CMD_FAST: begin
          if (fpg_r && live && !stop_r && rem_r != 16'd0 &&
              nemit_r < 7'(rsb_pkg::RESULT_LIMIT)) begin
            if (!ent_q[0].acked && tx_q[0] <= TW'(1) && ent_q[0].miss >= th) begin
              if (rem_r < ent_q[0].len) stop_set = 1'b1;
              else emit = 1'b1;
            end
          end
        end
        rsb_pkg::CMD_RETX: begin
          if (live && !stop_r && nemit_r < 7'(rsb_pkg::RESULT_LIMIT)) begin
            if (ent_q[0].retx && !ent_q[0].acked) begin
              if (rem_r < ent_q[0].len) begin
                stop_set = 1'b1;
              end else begin
                emit          = 1'b1;
                proc_ent.retx = 1'b0;
              end
            end
          end
        end
        rsb_pkg::CMD_MARK: begin
          if (live && !ent_q[0].acked) proc_ent.retx = 1'b1;
        end
        default: ;
      endcase
      if (emit && tx_q[0] != {TW{1'b1}}) proc_tx = tx_q[0] + TW'(1);
    end
  end

  assign shift_en = (state_r == S_WALK) || (state_r == S_CUM && retire);
  assign send_we  = (state_r == S_IDLE) && start && (in_cmd == rsb_pkg::CMD_SEND) &&
                    (cnt_r < CW'(QUEUE_DEPTH));
  assign wr_ent   = '{len: in_chunk_length, acked: 1'b0, retx: 1'b0, miss: 2'd0};

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    rsb_pkg::entry_t nb_ent;
    logic [TW-1:0]   nb_tx;
    if (k == QUEUE_DEPTH - 1) begin : g_tail
      assign nb_ent = proc_ent;
      assign nb_tx  = proc_tx;
    end else begin : g_mid
      assign nb_ent = ent_q[k+1];
      assign nb_tx  = tx_q[k+1];
    end
    rsb_cell #(.TRANSMIT_COUNT_WIDTH(TW)) u_cell (
      .clk       (clk),
      .shift_en  (shift_en),
      .wr_en     (send_we && cnt_r[IW-1:0] == IW'(k)),
      .shift_ent (nb_ent),
      .shift_tx  (nb_tx),
      .wr_ent    (wr_ent),
      .ent       (ent_q[k]),
      .tx        (tx_q[k])
    );
  end

  // gap range check
  logic        gvalid, ginr;
  logic [32:0] jend;
  assign gvalid = !gfail_r && (gs_r <= ge_r);
  assign ginr   = (jstart_r < 32'(cnt_r)) && (jstart_r >= 32'(sp_r));
  assign jend   = {1'b0, jstart_r} + {17'd0, ge_r - gs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      thr_r        <= 2'd3;
      cnt_r        <= '0;
      cum_r        <= '1;
      next_r       <= '0;
      sp_r         <= '0;
      gfail_r      <= 1'b0;
      ghigh_r      <= '0;
      fp_r         <= 1'b0;
      nemit_r      <= '0;
      hold_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      out_bytes_r  <= '0;
      out_high_r   <= '0;
      out_tsn_r    <= '0;
      out_len_r    <= '0;
      out_enter_r  <= 1'b0;
      out_status_r <= rsb_pkg::ST_OK;
      out_last_r   <= 1'b0;
      if (cfg_valid) thr_r <= cfg_data;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r     <= in_cmd;
            tval_r    <= in_tsn_value;
            gs_r      <= in_gap_start;
            ge_r      <= in_gap_end;
            inrec_r   <= in_in_recovery;
            rem_r     <= in_byte_budget;
            base_r    <= next_r - 32'(cnt_r);
            sum_r     <= '0;
            stop_r    <= 1'b0;
            reached_r <= 1'b0;
            nemit_r   <= '0;
            hold_v_r  <= 1'b0;
            step_r    <= '0;
            fpg_r     <= fp_r;
            if (in_cmd == rsb_pkg::CMD_FAST) fp_r <= 1'b0;
            if (in_cmd == rsb_pkg::CMD_GAP && in_first_block) begin
              sp_r    <= '0;
              gfail_r <= 1'b0;
              ghigh_r <= cum_r;
            end
            if (in_cmd == rsb_pkg::CMD_SEND) begin
              out_strobe_r <= 1'b1;
              out_last_r   <= 1'b1;
              out_tsn_r    <= next_r;
              if (send_we) begin
                cnt_r     <= cnt_r + CW'(1);
                next_r    <= next_r + 32'd1;
                out_len_r <= in_chunk_length;
              end else begin
                out_status_r <= rsb_pkg::ST_FULL;
              end
            end else if (in_cmd == rsb_pkg::CMD_CUM) begin
              state_r <= S_CUM;
            end else if (in_cmd > rsb_pkg::CMD_RETX) begin
              out_strobe_r <= 1'b1;
              out_last_r   <= 1'b1;
            end else begin
              state_r <= S_PREP1;
            end
          end
        end
        S_PREP1: begin
          jstart_r <= cum_r - base_r + 32'(gs_r);
          state_r  <= S_PREP2;
        end
        S_PREP2: begin
          ok_r <= (cmd_r == rsb_pkg::CMD_GAP) && gvalid && ginr;
          if (cmd_r == rsb_pkg::CMD_GAP && gvalid) begin
            if (!ginr) begin
              gfail_r <= 1'b1;
            end else begin
              jfirst_r <= jstart_r[CW-1:0];
              // block runs past the newest entry: mark up to it, then fail
              if (jend >= 33'(cnt_r)) begin
                gfail_r <= 1'b1;
                jlast_r <= cnt_r - CW'(1);
                sp_r    <= cnt_r - CW'(1);
              end else begin
                jlast_r <= jend[CW-1:0];
                sp_r    <= jend[CW-1:0];
              end
            end
          end
          state_r <= S_WALK;
        end
        S_WALK: begin
          step_r <= step_r + IW'(1);
          if (step_r == IW'(QUEUE_DEPTH - 1)) state_r <= S_FIN;
          if (stop_set) stop_r <= 1'b1;
          if (reach_set) reached_r <= 1'b1;
          if (hit) begin
            sum_r   <= rsb_pkg::sat_add(sum_r, ent_q[0].len);
            ghigh_r <= tsn_i;
          end
          if (emit) begin
            if (hold_v_r) begin
              out_strobe_r <= 1'b1;
              out_tsn_r    <= hold_tsn_r;
              out_len_r    <= hold_len_r;
            end
            hold_v_r   <= 1'b1;
            hold_tsn_r <= tsn_i;
            hold_len_r <= ent_q[0].len;
            nemit_r    <= nemit_r + 7'd1;
            rem_r      <= rem_r - ent_q[0].len;
          end
        end
        S_CUM: begin
          if (retire) begin
            cnt_r <= cnt_r - CW'(1);
            cum_r <= t0;
            if (!ent_q[0].acked) sum_r <= rsb_pkg::sat_add(sum_r, ent_q[0].len);
          end else begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          state_r      <= S_IDLE;
          out_strobe_r <= 1'b1;
          out_last_r   <= 1'b1;
          case (cmd_r) inside
            rsb_pkg::CMD_CUM: begin
              out_bytes_r <= sum_r;
              out_tsn_r   <= cum_r;
              sp_r        <= '0;
              if (inrec_r) fp_r <= 1'b1;
            end
            rsb_pkg::CMD_GAP: begin
              out_bytes_r <= sum_r;
              out_high_r  <= ghigh_r;
            end
            rsb_pkg::CMD_MISS: begin
              if (!inrec_r && reached_r) begin
                fp_r        <= 1'b1;
                out_enter_r <= 1'b1;
              end
            end
            rsb_pkg::CMD_FAST, rsb_pkg::CMD_RETX: begin
              if (hold_v_r) begin
                out_tsn_r <= hold_tsn_r;
                out_len_r <= hold_len_r;
              end else begin
                out_status_r <= rsb_pkg::ST_NONE;
              end
              hold_v_r <= 1'b0;
            end
            default: ;
          endcase
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy               = (state_r != S_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_strobe         = out_strobe_r;
  assign out_acked_bytes    = out_bytes_r;
  assign out_highest_acked  = out_high_r;
  assign out_tsn            = out_tsn_r;
  assign out_length         = out_len_r;
  assign out_enter_recovery = out_enter_r;
  assign out_status         = out_status_r;
  assign out_last           = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH)) else $error("entry count above depth");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |-> !busy) else $error("final item while busy");

  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_strobe || busy) else $error("accepted item dropped");

  a_emit_limit: assert property (@(posedge clk) disable iff (!rst_n)
    nemit_r <= 7'(rsb_pkg::RESULT_LIMIT)) else $error("too many gathered items");

endmodule

`default_nettype wire
